// ===== rtl/core/cpi_pkg.sv =====
package cpi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MEAS_W     = 16;
    localparam int DEB_W      = 8;
    localparam int FAULT_W    = 7;
    localparam int BEEP_W     = 9;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_FLOOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWR_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd5;

    localparam logic [MEAS_W-1:0] RST_VOLT_HIGH  = 16'd25300;
    localparam logic [MEAS_W-1:0] RST_VOLT_LOW   = 16'd19500;
    localparam logic [MEAS_W-1:0] RST_VOLT_FLOOR = 16'd1000;
    localparam logic [MEAS_W-1:0] RST_CUR_LIMIT  = 16'd3200;
    localparam logic [MEAS_W-1:0] RST_PWR_LIMIT  = 16'd7360;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE   = 8'd20;

    // opcodes; code 3 is unused
    localparam logic [1:0] OP_BUTTON = 2'd0;
    localparam logic [1:0] OP_FCHECK = 2'd1;
    localparam logic [1:0] OP_EARTH  = 2'd2;

    // fault bit positions
    localparam int FB_OVER_V  = 0;
    localparam int FB_UNDER_V = 1;
    localparam int FB_OVER_I  = 2;
    localparam int FB_EARTH   = 3;
    localparam int FB_OVER_P  = 4;
    localparam int FB_EMERG   = 5;
    localparam int FB_WELD    = 6;

    localparam logic [BEEP_W-1:0] BEEP_NONE       = 9'd0;
    localparam logic [BEEP_W-1:0] BEEP_FAULT      = 9'd500;
    localparam logic [BEEP_W-1:0] BEEP_CLEARED    = 9'd50;
    localparam logic [BEEP_W-1:0] BEEP_EARTH_LOST = 9'd300;
    localparam logic [BEEP_W-1:0] BEEP_REFUSED    = 9'd500;
    localparam logic [BEEP_W-1:0] BEEP_ON         = 9'd100;
    localparam logic [BEEP_W-1:0] BEEP_OFF        = 9'd200;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_FAULT      = 3'd1,
        EV_CLEARED    = 3'd2,
        EV_EARTH_LOST = 3'd3,
        EV_EARTH_OK   = 3'd4,
        EV_REFUSED    = 3'd5,
        EV_ON         = 3'd6,
        EV_OFF        = 3'd7
    } t_event;

    typedef struct packed {
        logic [MEAS_W-1:0] volt_limit_high;
        logic [MEAS_W-1:0] volt_limit_low;
        logic [MEAS_W-1:0] volt_presence_floor;
        logic [MEAS_W-1:0] current_limit;
        logic [MEAS_W-1:0] power_limit;
        logic [DEB_W-1:0]  debounce_samples;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        opcode;
        logic              button_level;
        logic              emergency_stop;
        logic              relay_welded;
        logic              earth_present;
        logic              meter_ready;
        logic [MEAS_W-1:0] vrms;
        logic [MEAS_W-1:0] irms;
        logic [MEAS_W-1:0] power;
    } t_item;

    typedef struct packed {
        logic               relay_closed;
        logic [FAULT_W-1:0] fault_bits;
        logic [BEEP_W-1:0]  buzzer_ticks;
        logic [2:0]         event_res;
    } t_result;

endpackage

// ===== rtl/core/cpi_in_if.sv =====
interface cpi_in_if;
    import cpi_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic              button_level;
    logic              emergency_stop;
    logic              relay_welded;
    logic              earth_present;
    logic              meter_ready;
    logic [MEAS_W-1:0] vrms;
    logic [MEAS_W-1:0] irms;
    logic [MEAS_W-1:0] power;

    modport source (
        output valid, opcode, button_level, emergency_stop, relay_welded,
               earth_present, meter_ready, vrms, irms, power,
        input  ready
    );

    modport sink (
        input  valid, opcode, button_level, emergency_stop, relay_welded,
               earth_present, meter_ready, vrms, irms, power,
        output ready
    );
endinterface

// ===== rtl/core/cpi_out_if.sv =====
interface cpi_out_if;
    import cpi_pkg::*;

    logic               valid;
    logic               ready;
    logic               relay_closed;
    logic [FAULT_W-1:0] fault_bits;
    logic [BEEP_W-1:0]  buzzer_ticks;
    logic [2:0]         event_res;

    modport source (
        output valid, relay_closed, fault_bits, buzzer_ticks, event_res,
        input  ready
    );

    modport sink (
        input  valid, relay_closed, fault_bits, buzzer_ticks, event_res,
        output ready
    );
endinterface

// ===== rtl/core/charger_protection_interlock.sv =====
// Protection interlock for a single-phase charger. Every input beat is one
// event (button sample, periodic fault check or earth check) and yields
// exactly one result beat with the relay drive, the fault bits, a beep
// length and an event code. A beat is taken every cycle while the output
// is not stalled; it passes the input register, the combinational
// decision logic and the result register in turn. The result register
// lets the next beat enter while a result waits on a stalled output.
// Limit and debounce registers should only be rewritten while no beat is
// in flight.
module charger_protection_interlock
    import cpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cpi_in_if.sink                i_in,
    cpi_out_if.source             o_out
);

    t_cfg    cfg;
    t_result res;
    t_item   in_item;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    fire;

    assign fire       = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | fire;

    assign in_item.opcode         = i_in.opcode;
    assign in_item.button_level   = i_in.button_level;
    assign in_item.emergency_stop = i_in.emergency_stop;
    assign in_item.relay_welded   = i_in.relay_welded;
    assign in_item.earth_present  = i_in.earth_present;
    assign in_item.meter_ready    = i_in.meter_ready;
    assign in_item.vrms           = i_in.vrms;
    assign in_item.irms           = i_in.irms;
    assign in_item.power          = i_in.power;

    cpi_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cpi_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.relay_closed = r_out.relay_closed;
    assign o_out.fault_bits   = r_out.fault_bits;
    assign o_out.buzzer_ticks = r_out.buzzer_ticks;
    assign o_out.event_res    = r_out.event_res;

endmodule

// ===== rtl/core/cpi_regs.sv =====
module cpi_regs
    import cpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volt_limit_high     <= RST_VOLT_HIGH;
            r_cfg.volt_limit_low      <= RST_VOLT_LOW;
            r_cfg.volt_presence_floor <= RST_VOLT_FLOOR;
            r_cfg.current_limit       <= RST_CUR_LIMIT;
            r_cfg.power_limit         <= RST_PWR_LIMIT;
            r_cfg.debounce_samples    <= RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOLT_HIGH:  r_cfg.volt_limit_high     <= i_cfg_data;
                CFG_VOLT_LOW:   r_cfg.volt_limit_low      <= i_cfg_data;
                CFG_VOLT_FLOOR: r_cfg.volt_presence_floor <= i_cfg_data;
                CFG_CUR_LIMIT:  r_cfg.current_limit       <= i_cfg_data;
                CFG_PWR_LIMIT:  r_cfg.power_limit         <= i_cfg_data;
                CFG_DEBOUNCE:   r_cfg.debounce_samples    <= i_cfg_data[DEB_W-1:0];
                default: ;  // writes past the last register are dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/cpi_engine.sv =====
module cpi_engine
    import cpi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic               r_stable;
    logic [DEB_W-1:0]   r_count;
    logic               r_charging;
    logic [FAULT_W-1:0] r_faults;

    logic               n_stable;
    logic [DEB_W-1:0]   n_count;
    logic               n_charging;
    logic [FAULT_W-1:0] n_faults;
    logic [BEEP_W-1:0]  beep;
    t_event             ev;

    logic [DEB_W-1:0]   cnt_inc;
    logic               meas_on;
    logic [FAULT_W-1:0] chk_faults;

    assign cnt_inc = r_count + DEB_W'(1);
    assign meas_on = i_item.meter_ready & r_charging;

    // fresh fault set for a periodic check; the earth bit is carried over
    always_comb begin
        chk_faults             = '0;
        chk_faults[FB_EARTH]   = r_faults[FB_EARTH];
        chk_faults[FB_EMERG]   = i_item.emergency_stop;
        chk_faults[FB_WELD]    = i_item.relay_welded;
        chk_faults[FB_OVER_V]  = meas_on & (i_item.vrms > i_cfg.volt_limit_high);
        chk_faults[FB_UNDER_V] = meas_on & (i_item.vrms < i_cfg.volt_limit_low)
                                 & (i_item.vrms > i_cfg.volt_presence_floor);
        chk_faults[FB_OVER_I]  = meas_on & (i_item.irms > i_cfg.current_limit);
        chk_faults[FB_OVER_P]  = meas_on & (i_item.power > i_cfg.power_limit);
    end

    always_comb begin
        n_stable   = r_stable;
        n_count    = r_count;
        n_charging = r_charging;
        n_faults   = r_faults;
        beep       = BEEP_NONE;
        ev         = EV_NONE;
        unique case (i_item.opcode)
            OP_BUTTON: begin
                if (i_item.button_level == r_stable) begin
                    n_count = '0;
                end else if (cnt_inc < i_cfg.debounce_samples) begin
                    n_count = cnt_inc;
                end else begin
                    n_stable = i_item.button_level;
                    n_count  = '0;
                    // only a qualified press acts; a release is silent
                    if (!i_item.button_level) begin
                        if (r_charging) begin
                            n_charging = 1'b0;
                            beep       = BEEP_OFF;
                            ev         = EV_OFF;
                        end else if (r_faults != '0) begin
                            beep = BEEP_REFUSED;
                            ev   = EV_REFUSED;
                        end else begin
                            n_charging = 1'b1;
                            beep       = BEEP_ON;
                            ev         = EV_ON;
                        end
                    end
                end
            end
            OP_FCHECK: begin
                if (chk_faults != r_faults) begin
                    n_faults = chk_faults;
                    if (chk_faults != '0) begin
                        n_charging = 1'b0;
                        beep       = BEEP_FAULT;
                        ev         = EV_FAULT;
                    end else begin
                        beep = BEEP_CLEARED;
                        ev   = EV_CLEARED;
                    end
                end
            end
            OP_EARTH: begin
                if (i_item.earth_present) begin
                    if (r_faults[FB_EARTH]) begin
                        n_faults[FB_EARTH] = 1'b0;
                        ev                 = EV_EARTH_OK;
                    end
                end else if (!r_faults[FB_EARTH]) begin
                    n_faults[FB_EARTH] = 1'b1;
                    n_charging         = 1'b0;
                    beep               = BEEP_EARTH_LOST;
                    ev                 = EV_EARTH_LOST;
                end
            end
            default: ;  // unused opcode reports state only
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b1;
            r_count    <= '0;
            r_charging <= 1'b0;
            r_faults   <= '0;
        end else if (i_fire) begin
            r_stable   <= n_stable;
            r_count    <= n_count;
            r_charging <= n_charging;
            r_faults   <= n_faults;
        end
    end

    assign o_res.relay_closed = n_charging;
    assign o_res.fault_bits   = n_faults;
    assign o_res.buzzer_ticks = beep;
    assign o_res.event_res    = ev;

endmodule

// ===== rtl/core/cpi_checker.sv =====
module cpi_checker
    import cpi_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_relay_closed,
    input logic [FAULT_W-1:0] i_fault_bits,
    input logic [BEEP_W-1:0]  i_buzzer_ticks,
    input logic [2:0]         i_event_res
);

    // relay never shown closed alongside any fault
    a_no_close_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_relay_closed && (i_fault_bits != '0)))
        else $error("relay closed with faults set");

    a_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_event_res == EV_ON))
        |-> (i_relay_closed && (i_buzzer_ticks == BEEP_ON)))
        else $error("start beat inconsistent");

    a_fault_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_event_res == EV_FAULT))
        |-> (!i_relay_closed && (i_fault_bits != '0) && (i_buzzer_ticks == BEEP_FAULT)))
        else $error("fault beat left relay closed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_relay_closed) && $stable(i_fault_bits)
             && $stable(i_buzzer_ticks) && $stable(i_event_res)))
        else $error("stalled result beat changed");

endmodule

bind charger_protection_interlock cpi_checker u_cpi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_relay_closed (o_out.relay_closed),
    .i_fault_bits   (o_out.fault_bits),
    .i_buzzer_ticks (o_out.buzzer_ticks),
    .i_event_res    (o_out.event_res)
);
